/* src/ape_pkg.sv */
package ape_pkg;

    // register map index, byte address is 4 times this
    typedef enum logic [1:0] {
        REG_SATURATION = 2'd0,
        REG_BRIGHTNESS = 2'd1,
        REG_OPACITY    = 2'd2,
        REG_BACKGROUND = 2'd3
    } reg_idx_t;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // reset values of the registers
    localparam logic [10:0] SAT_OFF        = 11'h7FF;
    localparam logic [8:0]  BRIGHT_RESET   = 9'h000;
    localparam logic [7:0]  OPACITY_RESET  = 8'hFF;
    localparam logic [31:0] BG_RESET       = 32'hFF00_0000;

    // luma weights, sum to 256
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd151;
    localparam logic [7:0] LUMA_B = 8'd28;

    localparam logic [7:0] CHAN_MAX = 8'hFF;

    // register contents as seen by the datapath
    typedef struct packed {
        logic [10:0] saturation;
        logic [8:0]  brightness;
        logic [7:0]  opacity;
        logic [31:0] background_color;
    } cfg_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

/* src/argb_pixel_effect.sv */
// a word accepted into the first stage moves through each register stage in turn to the output
// throughput: one word per cycle while m_axis_tready is high, four register stages with their own valid bits
// a stage loads whenever it is empty or the stage after it moves, so a held
// output word does not block earlier stages from filling
// reset: rst_n asynchronous active low, clears valid bits and loads register defaults
// (saturation off, brightness 0, opacity 255, background 0xFF000000)
module argb_pixel_effect (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // [31:0] src_pixel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // [31:0] out_pixel
    output logic [0:0]                    m_axis_tuser,   // [0] drawn
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ape_pkg::ADDR_W-1:0]    paddr,
    input  logic [ape_pkg::DATA_W-1:0]    pwdata,
    output logic [ape_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import ape_pkg::*;

    cfg_t      cfg;
    stage_en_t en;
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      v1_next, v2_next, v3_next, v4_next;
    logic      drawn;

    ape_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ready chain, each stage loads when empty or draining
    always_comb
    begin
        en.s4 = !v4_reg || m_axis_tready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    // valid bits follow the data
    always_comb
    begin
        v1_next = en.s1 ? s_axis_tvalid : v1_reg;
        v2_next = en.s2 ? v1_reg : v2_reg;
        v3_next = en.s3 ? v2_reg : v3_reg;
        v4_next = en.s4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    ape_datapath u_datapath (
        .clk       (clk),
        .cfg       (cfg),
        .en        (en),
        .src_pixel (s_axis_tdata),
        .out_pixel (m_axis_tdata),
        .drawn     (drawn)
    );

    assign s_axis_tready   = en.s1;
    assign m_axis_tvalid   = v4_reg;
    assign m_axis_tuser[0] = drawn;

    // an accepted word always lands in stage 1
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted word not captured in stage 1");

    // a full stage 3 behind a stalled output keeps its word
    a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && v4_reg && !m_axis_tready |=> v3_reg)
        else $error("stage 3 word lost during stall");

    // a word moving out of stage 3 reaches the output stage
    a_s3_to_s4: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && en.s4 |=> v4_reg)
        else $error("stage 3 word dropped on advance");

    // an undrawn result carries a zero pixel
    a_undrawn_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'h0)
        else $error("undrawn result with nonzero pixel");

endmodule

/* src/ape_regs.sv */
module ape_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ape_pkg::ADDR_W-1:0]    paddr,
    input  logic [ape_pkg::DATA_W-1:0]    pwdata,
    output logic [ape_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output ape_pkg::cfg_t                 cfg
);
    import ape_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SATURATION: cfg_next.saturation       = pwdata[10:0];
                REG_BRIGHTNESS: cfg_next.brightness       = pwdata[8:0];
                REG_OPACITY:    cfg_next.opacity          = pwdata[7:0];
                REG_BACKGROUND: cfg_next.background_color = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.saturation       <= SAT_OFF;
            cfg_reg.brightness       <= BRIGHT_RESET;
            cfg_reg.opacity          <= OPACITY_RESET;
            cfg_reg.background_color <= BG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, signed registers sign extended
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (idx)
                REG_SATURATION: prdata = {{21{cfg_reg.saturation[10]}}, cfg_reg.saturation};
                REG_BRIGHTNESS: prdata = {{23{cfg_reg.brightness[8]}}, cfg_reg.brightness};
                REG_OPACITY:    prdata = {24'h0, cfg_reg.opacity};
                REG_BACKGROUND: prdata = cfg_reg.background_color;
                default:        prdata = '0;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/ape_datapath.sv */
module ape_datapath (
    input  logic              clk,
    input  ape_pkg::cfg_t     cfg,
    input  ape_pkg::stage_en_t en,
    input  logic [31:0]       src_pixel,
    output logic [31:0]       out_pixel,
    output logic              drawn
);
    import ape_pkg::*;

    // stage 1: source word and luma
    logic [31:0] px1_reg;
    logic [7:0]  gray1_reg;
    logic [15:0] gray_sum;

    // stage 2: chroma products and alpha product
    logic [31:0]             px2_reg;
    logic [7:0]              gray2_reg;
    logic [2:0][19:0]        prod2_reg;
    logic [2:0][19:0]        prod2_next;
    logic [15:0]             ap2_reg;

    // stage 3: saturated channels and scaled alpha
    logic [2:0][7:0] chan3_reg;
    logic [2:0][7:0] chan3_next;
    logic [7:0]      alpha3_reg;
    logic [16:0]     alpha_q;

    // stage 4: output word
    logic [31:0] pix4_reg;
    logic [31:0] pix4_next;
    logic        drawn4_reg;
    logic        drawn4_next;
    logic [2:0][7:0] chan4;

    logic sat_en;

    assign sat_en = (cfg.saturation != SAT_OFF);

    // luma from the source word
    assign gray_sum = 16'(src_pixel[23:16]) * 16'(LUMA_R)
                    + 16'(src_pixel[15:8])  * 16'(LUMA_G)
                    + 16'(src_pixel[7:0])   * 16'(LUMA_B);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            px1_reg   <= src_pixel;
            gray1_reg <= gray_sum[15:8];
        end
    end

    // distance from gray times gain
    always_comb
    begin
        logic signed [8:0]  diff;
        logic signed [10:0] gain;
        logic signed [19:0] prod;
        gain = $signed(cfg.saturation);
        for (int c = 0; c < 3; c++)
        begin
            diff = $signed({1'b0, px1_reg[8*c +: 8]}) - $signed({1'b0, gray1_reg});
            prod = diff * gain;
            prod2_next[c] = prod;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            px2_reg   <= px1_reg;
            gray2_reg <= gray1_reg;
            prod2_reg <= prod2_next;
            ap2_reg   <= 16'(px1_reg[31:24]) * 16'(cfg.opacity);
        end
    end

    // floor shift, add back gray, clamp, or pass the source channels when saturation is off; alpha over 255
    always_comb
    begin
        logic signed [11:0] shifted;
        logic signed [12:0] sum;
        for (int c = 0; c < 3; c++)
        begin
            shifted = $signed(prod2_reg[c][19:8]);
            sum     = $signed({5'b0, gray2_reg}) + 13'(shifted);
            if (!sat_en)
                chan3_next[c] = px2_reg[8*c +: 8];
            else if (sum < 0)
                chan3_next[c] = 8'h00;
            else if (sum > $signed({5'b0, CHAN_MAX}))
                chan3_next[c] = CHAN_MAX;
            else
                chan3_next[c] = sum[7:0];
        end
    end

    assign alpha_q = (17'(ap2_reg) + 17'(ap2_reg[15:8]) + 17'd1) >> 8;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            chan3_reg  <= chan3_next;
            alpha3_reg <= alpha_q[7:0];
        end
    end

    // brightness, clamp and final select
    always_comb
    begin
        logic signed [10:0] bsum;
        for (int c = 0; c < 3; c++)
        begin
            bsum = $signed({3'b0, chan3_reg[c]}) + 11'($signed(cfg.brightness));
            if (bsum < 0)
                chan4[c] = 8'h00;
            else if (bsum > $signed({3'b0, CHAN_MAX}))
                chan4[c] = CHAN_MAX;
            else
                chan4[c] = bsum[7:0];
        end
        if (cfg.opacity == 8'h00)
        begin
            pix4_next   = '0;
            drawn4_next = 1'b0;
        end
        else if (alpha3_reg == 8'h00)
        begin
            pix4_next   = cfg.background_color;
            drawn4_next = 1'b1;
        end
        else
        begin
            pix4_next   = {alpha3_reg, chan4[2], chan4[1], chan4[0]};
            drawn4_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            pix4_reg   <= pix4_next;
            drawn4_reg <= drawn4_next;
        end
    end

    assign out_pixel = pix4_reg;
    assign drawn     = drawn4_reg;

endmodule
